FILE: rtl/core/rlte_pkg.sv
// Shared types, request codes and helpers for the relay logic term evaluator.
package rlte_pkg;

  // Request kinds carried in the low bits of s_tuser
  localparam logic [2:0] REQ_LOAD   = 3'd0;
  localparam logic [2:0] REQ_SET    = 3'd1;
  localparam logic [2:0] REQ_CLEAR  = 3'd2;
  localparam logic [2:0] REQ_MASK   = 3'd3;
  localparam logic [2:0] REQ_RECALC = 3'd4;

  // Term tables
  localparam logic [1:0] TBL_PREPARE = 2'd0;
  localparam logic [1:0] TBL_MAIN    = 2'd1;
  localparam logic [1:0] TBL_STATIC  = 2'd2;
  localparam logic [1:0] TBL_DYNAMIC = 2'd3;

  // Configuration register indexes (byte address is 8 * index)
  localparam logic [2:0] REG_PREPARE_COUNT = 3'd0;
  localparam logic [2:0] REG_MAIN_COUNT    = 3'd1;
  localparam logic [2:0] REG_STATIC_COUNT  = 3'd2;
  localparam logic [2:0] REG_DYNAMIC_COUNT = 3'd3;
  localparam logic [2:0] REG_BASE_MASK     = 3'd4;

  localparam int COUNT_W = 9;
  localparam int WORD_W  = 64;
  localparam int LIM_W   = 13;  // holds any term limit up to 4096

  // Commands from controller to datapath
  typedef struct packed {
    logic       mem_we;
    logic       mem_re;
    logic [1:0] tbl;
    logic       set_bit;
    logic       clr_bit;
    logic       mask_st;
    logic       start;
    logic       capture;
  } rlte_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic rd_busy;
  } rlte_stat_t;

  // A count above the table size acts as the table size
  function automatic logic [LIM_W-1:0] limit_count(input logic [COUNT_W-1:0] cnt,
                                                    input logic [LIM_W-1:0] max_t);
    logic [LIM_W-1:0] c;
    c = LIM_W'(cnt);
    return (c > max_t) ? max_t : c;
  endfunction

endpackage

FILE: rtl/core/rlte_ctrl.sv
// Controller: request decode, term table scan sequencing and result handshake.
module rlte_ctrl #(
  parameter int IDX_W     = 8,
  parameter int CNT_W     = 9
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [2:0]                 req_type,
  input  logic [1:0]                 table_select,
  input  logic [7:0]                 entry_index,
  input  logic [3:0][CNT_W-1:0]      lim,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output rlte_pkg::rlte_cmd_t        cmd,
  output logic [IDX_W-1:0]           mem_idx,
  input  rlte_pkg::rlte_stat_t       stat
);
  import rlte_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t           state;
  logic [1:0]       scan_tbl;
  logic [CNT_W-1:0] scan_cnt;
  logic             accept;
  logic             scan_more;
  logic             out_free;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign scan_more = (scan_cnt < lim[scan_tbl]);
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    cmd     = '0;
    mem_idx = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_LOAD: begin
              cmd.tbl    = table_select;
              mem_idx    = IDX_W'(entry_index);
              cmd.mem_we = (LIM_W'(entry_index) < LIM_W'(lim[table_select]));
            end
            REQ_SET:    cmd.set_bit = 1'b1;
            REQ_CLEAR:  cmd.clr_bit = 1'b1;
            REQ_MASK:   cmd.mask_st = 1'b1;
            REQ_RECALC: cmd.start   = 1'b1;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.tbl    = scan_tbl;
        mem_idx    = scan_cnt[IDX_W-1:0];
        cmd.mem_re = scan_more;
      end
      ST_DONE: cmd.capture = !stat.rd_busy && out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      scan_tbl <= TBL_PREPARE;
      scan_cnt <= '0;
    end else begin
      // a capture refills the slot even as the old word leaves
      if (cmd.capture) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && req_type == REQ_RECALC) begin
            state    <= ST_SCAN;
            scan_tbl <= TBL_PREPARE;
            scan_cnt <= '0;
          end
        end
        ST_SCAN: begin
          if (scan_more) begin
            scan_cnt <= scan_cnt + 1'b1;
          end else if (scan_tbl == TBL_DYNAMIC) begin
            state <= ST_DONE;
          end else begin
            scan_tbl <= scan_tbl + 1'b1;
            scan_cnt <= '0;
          end
        end
        ST_DONE: begin
          if (cmd.capture) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/rlte_dp.sv
// Datapath: status vector, term memory, per-stage accumulators, result register.
module rlte_dp #(
  parameter int IDX_W     = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rlte_pkg::rlte_cmd_t  cmd,
  input  logic [IDX_W-1:0]     mem_idx,
  output rlte_pkg::rlte_stat_t stat,
  input  logic [63:0]          cond_mask,
  input  logic [63:0]          result_bits,
  input  logic [5:0]           bit_number,
  input  logic [63:0]          keep_mask,
  input  logic [63:0]          force_mask,
  input  logic [63:0]          base_mask,
  output logic [63:0]          output_word,
  output logic [63:0]          sensitive_word,
  output logic                 was_pending
);
  import rlte_pkg::*;

  localparam int ADDR_W = IDX_W + 2;
  localparam int DEPTH  = 4 << IDX_W;

  // Each entry: condition mask in the upper half, result word in the lower
  logic [2*WORD_W-1:0] term_mem [DEPTH];
  logic [2*WORD_W-1:0] rd_data;
  logic                rd_vld;
  logic [1:0]          rd_tbl;
  logic [ADDR_W-1:0]   addr;

  logic [WORD_W-1:0] status;
  logic [WORD_W-1:0] status_next;
  logic              pending;
  logic              pend_snap;
  logic [WORD_W-1:0] prep_acc;
  logic [WORD_W-1:0] main_acc;
  logic [WORD_W-1:0] sens_acc;
  logic [WORD_W-1:0] cmp_word;
  logic              hit;

  assign addr         = {cmd.tbl, mem_idx};
  assign stat.rd_busy = rd_vld;

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      term_mem[addr] <= {cond_mask, result_bits};
    end
    if (cmd.mem_re) begin
      rd_data <= term_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.mem_re;
    end
    rd_tbl <= cmd.tbl;
  end

  // Prepare terms see the raw status; later stages see it with prepare results added
  assign cmp_word = (rd_tbl == TBL_PREPARE) ? status : (status | prep_acc);
  assign hit      = rd_vld && ((rd_data[2*WORD_W-1:WORD_W] & ~cmp_word) == '0);

  always_comb begin
    status_next = status;
    if (cmd.set_bit) begin
      status_next = status | (WORD_W'(1) << bit_number);
    end else if (cmd.clr_bit) begin
      status_next = status & ~(WORD_W'(1) << bit_number);
    end else if (cmd.mask_st) begin
      status_next = (status & keep_mask) | force_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status    <= '0;
      pending   <= 1'b0;
      pend_snap <= 1'b0;
      prep_acc  <= '0;
      main_acc  <= '0;
      sens_acc  <= '0;
    end else begin
      status <= status_next;
      if (cmd.start) begin
        pend_snap <= pending;
        pending   <= 1'b0;
        prep_acc  <= '0;
        main_acc  <= '0;
        sens_acc  <= '0;
      end else begin
        if (status_next != status) begin
          pending <= 1'b1;
        end
        if (hit) begin
          case (rd_tbl)
            TBL_PREPARE: prep_acc <= prep_acc | rd_data[WORD_W-1:0];
            TBL_MAIN:    main_acc <= main_acc | rd_data[WORD_W-1:0];
            default:     sens_acc <= sens_acc | rd_data[WORD_W-1:0];
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      output_word    <= main_acc;
      sensitive_word <= base_mask | sens_acc;
      was_pending    <= pend_snap;
    end
  end

endmodule

FILE: rtl/core/relay_logic_term_evaluator_top.sv
// Top level of the relay logic term evaluator: ports, register file, unit wiring.
//
// Relay logic term evaluator. Keeps a 64-bit contact status and four term
// tables (prepare, main, static sensitive, dynamic sensitive) in one
// single-port memory of 4 x MAX_TERMS entries, each a condition mask and a
// result word. Load, set, clear and mask words never hold the input. A
// recalculate word scans the tables in order, one term read per cycle from
// the single memory port, each table up to its count (capped at MAX_TERMS);
// no further word is taken until the scan is over and the result captured.
// The result word sits in an output register, so other words are taken while
// it waits, but a further recalculate holds in its final step until the
// result slot frees. Table memory is not cleared: a term must be loaded
// before a recalculate covers it. Loads at or above the table's count are
// dropped.
// Registers (APB, byte address 8 * index): prepare, main, static and dynamic
// counts (9 bits, index 0 to 3) and the base sensitive mask (index 4).
module relay_logic_term_evaluator_top #(
  parameter int MAX_TERMS = 256
) (
  input  logic         clk,
  input  logic         rst,
  // slave word
  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tdata, low bit up: entry_index[7:0], cond_mask[71:8], result_bits[135:72],
  // bit_number[141:136], keep_mask[205:142], force_mask[269:206], zero pad
  input  logic [271:0] s_tdata,
  // s_tuser, low bit up: req_type[2:0], table_select[4:3]
  input  logic [4:0]   s_tuser,
  // master word
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata, low bit up: output_word[63:0], sensitive_word[127:64]
  output logic [127:0] m_tdata,
  // m_tuser: was_pending[0]
  output logic [0:0]   m_tuser,
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  import rlte_pkg::*;

  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam logic [LIM_W-1:0] MaxT = LIM_W'(MAX_TERMS);

  // Unpacked input word
  logic [2:0]  req_type;
  logic [1:0]  table_select;
  logic [7:0]  entry_index;
  logic [63:0] cond_mask;
  logic [63:0] result_bits;
  logic [5:0]  bit_number;
  logic [63:0] keep_mask;
  logic [63:0] force_mask;

  assign req_type     = s_tuser[2:0];
  assign table_select = s_tuser[4:3];
  assign entry_index  = s_tdata[7:0];
  assign cond_mask    = s_tdata[71:8];
  assign result_bits  = s_tdata[135:72];
  assign bit_number   = s_tdata[141:136];
  assign keep_mask    = s_tdata[205:142];
  assign force_mask   = s_tdata[269:206];

  // Register file
  logic [3:0][COUNT_W-1:0] cfg_count;
  logic [63:0]             base_mask;
  logic [3:0][CNT_W-1:0]   lim;
  logic                    cfg_wr;
  logic [2:0]              cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_count <= '0;
      base_mask <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PREPARE_COUNT: cfg_count[TBL_PREPARE] <= pwdata[COUNT_W-1:0];
        REG_MAIN_COUNT:    cfg_count[TBL_MAIN]    <= pwdata[COUNT_W-1:0];
        REG_STATIC_COUNT:  cfg_count[TBL_STATIC]  <= pwdata[COUNT_W-1:0];
        REG_DYNAMIC_COUNT: cfg_count[TBL_DYNAMIC] <= pwdata[COUNT_W-1:0];
        REG_BASE_MASK:     base_mask              <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PREPARE_COUNT: prdata = 64'(cfg_count[TBL_PREPARE]);
      REG_MAIN_COUNT:    prdata = 64'(cfg_count[TBL_MAIN]);
      REG_STATIC_COUNT:  prdata = 64'(cfg_count[TBL_STATIC]);
      REG_DYNAMIC_COUNT: prdata = 64'(cfg_count[TBL_DYNAMIC]);
      REG_BASE_MASK:     prdata = base_mask;
      default:           prdata = '0;
    endcase
  end

  // Counts beyond the table size act as the table size
  always_comb begin
    for (int t = 0; t < 4; t++) begin
      lim[t] = CNT_W'(limit_count(cfg_count[t], MaxT));
    end
  end

  rlte_cmd_t        cmd;
  rlte_stat_t       stat;
  logic [IDX_W-1:0] mem_idx;
  logic [63:0]      output_word;
  logic [63:0]      sensitive_word;
  logic             was_pending;

  rlte_ctrl #(
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .req_type     (req_type),
    .table_select (table_select),
    .entry_index  (entry_index),
    .lim          (lim),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .cmd          (cmd),
    .mem_idx      (mem_idx),
    .stat         (stat)
  );

  rlte_dp #(
    .IDX_W     (IDX_W)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .mem_idx        (mem_idx),
    .stat           (stat),
    .cond_mask      (cond_mask),
    .result_bits    (result_bits),
    .bit_number     (bit_number),
    .keep_mask      (keep_mask),
    .force_mask     (force_mask),
    .base_mask      (base_mask),
    .output_word    (output_word),
    .sensitive_word (sensitive_word),
    .was_pending    (was_pending)
  );

  assign m_tdata = {sensitive_word, output_word};
  assign m_tuser = was_pending;

endmodule

FILE: rtl/core/rlte_chk.sv
// Port-level checker for the relay logic term evaluator, bound to the top level.
module rlte_chk (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [4:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata
);
  import rlte_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word dropped or changed while stalled");

  // A recalculate closes the input while the tables are scanned
  a_recalc_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[2:0] == REQ_RECALC |=> !s_tready)
    else $error("input open during recalculate");

  // A new result only appears at the end of a scan
  a_out_after_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result raised outside a recalculate");

  // Reset empties the result slot
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind relay_logic_term_evaluator_top rlte_chk u_chk (.*);

FILE: bench/tb_top.sv
// Self-checking bench for the relay logic term evaluator: stream words in, results checked.
`timescale 1ns / 100ps

module tb_top;
  import rlte_pkg::*;

  localparam int TERM_LIMIT = 256;
  // A full scan reads every table once; allow that plus the pipeline tail.
  localparam int SCAN_SETTLE = 4 * TERM_LIMIT + 16;
  // Cycles without any accepted word before the run is abandoned. The slowest
  // legal gap is an idle settle or drain (SCAN_SETTLE) or one full scan plus a
  // short receiver stall, so this is many times that.
  localparam int STALL_LIMIT = 50000;

  // Request codes the block ignores
  localparam logic [2:0] REQ_RSVD_A = 3'd5;
  localparam logic [2:0] REQ_RSVD_B = 3'd6;
  localparam logic [2:0] REQ_RSVD_C = 3'd7;

  typedef struct {
    logic [63:0] out_word;
    logic [63:0] sens_word;
    logic        pend;
  } recalc_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [271:0] s_tdata = '0;
  logic [4:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic [0:0]   m_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [5:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;

  relay_logic_term_evaluator_top #(
    .MAX_TERMS(TERM_LIMIT)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: contact status, pending flag, term tables, registers.
  // term_loaded tracks which slots hold a real term, so a scan never covers an
  // unwritten slot.
  // ---------------------------------------------------------------------------
  logic [63:0] contact_status;
  logic        change_pending;
  logic [63:0] term_cond [4][TERM_LIMIT];
  logic [63:0] term_out  [4][TERM_LIMIT];
  bit          term_loaded [4][TERM_LIMIT];
  logic [8:0]  term_count [4];
  logic [63:0] base_sens;

  recalc_result_t results_due[$];
  int errors = 0;

  // percentages of cycles in which each side holds off
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;

  function automatic int terms_in_use(input logic [8:0] cnt);
    return (cnt > TERM_LIMIT) ? TERM_LIMIT : int'(cnt);
  endfunction

  // OR of the result words of every term in one table whose mask is covered
  function automatic logic [63:0] fired_terms(input logic [1:0] tbl, input logic [63:0] eff);
    logic [63:0] acc;
    acc = '0;
    for (int i = 0; i < terms_in_use(term_count[tbl]); i++) begin
      if ((term_cond[tbl][i] & ~eff) == '0) acc |= term_out[tbl][i];
    end
    return acc;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Sparse masks over the low contacts so terms really fire; now and then a
  // dense or an empty mask.
  function automatic logic [63:0] term_mask();
    logic [63:0] m;
    int pick;
    m = '0;
    pick = $urandom_range(7);
    if (pick == 0) begin
      m = rand64();
    end else if (pick != 1) begin
      repeat ($urandom_range(3)) m |= 64'd1 << $urandom_range(15);
    end
    return m;
  endfunction

  function automatic logic [271:0] pack_word(input logic [7:0] idx, input logic [63:0] cond,
                                             input logic [63:0] res, input logic [5:0] bitn,
                                             input logic [63:0] keep, input logic [63:0] frc);
    return {2'b00, frc, keep, bitn, res, cond, idx};
  endfunction

  task automatic move_status(input logic [63:0] next);
    if (next != contact_status) change_pending = 1'b1;
    contact_status = next;
  endtask

  // Apply one accepted word to the shadow; a recalculate queues its result.
  task automatic predict_word(input logic [2:0] req, input logic [1:0] tbl,
                              input logic [271:0] data);
    logic [7:0]     idx;
    logic [63:0]    cond, res, keep, frc, eff;
    logic [5:0]     bitn;
    recalc_result_t r;
    idx  = data[7:0];
    cond = data[71:8];
    res  = data[135:72];
    bitn = data[141:136];
    keep = data[205:142];
    frc  = data[269:206];
    case (req)
      REQ_LOAD: begin
        // slots at or above the count in use are dropped
        if (int'(idx) < terms_in_use(term_count[tbl])) begin
          term_cond[tbl][idx] = cond;
          term_out[tbl][idx] = res;
          term_loaded[tbl][idx] = 1'b1;
        end
      end
      REQ_SET:   move_status(contact_status | (64'd1 << bitn));
      REQ_CLEAR: move_status(contact_status & ~(64'd1 << bitn));
      REQ_MASK:  move_status((contact_status & keep) | frc);
      REQ_RECALC: begin
        eff = contact_status | fired_terms(TBL_PREPARE, contact_status);
        r.out_word = fired_terms(TBL_MAIN, eff);
        r.sens_word = base_sens | fired_terms(TBL_STATIC, eff) | fired_terms(TBL_DYNAMIC, eff);
        r.pend = change_pending;
        change_pending = 1'b0;
        results_due.insert(results_due.size(), r);
      end
      default: ;  // reserved codes do nothing
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Drivers. Everything changes at the falling edge; handshakes are looked at
  // on the rising edge, before the block's own registers move.
  // ---------------------------------------------------------------------------

  // Send one word. Valid stays up across back-to-back words, so the only
  // assignment to it in a step is either the raise or the drop.
  task automatic send_word(input logic [2:0] req, input logic [1:0] tbl,
                           input logic [271:0] data);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= data;
    s_tuser <= {tbl, req};
    do @(posedge clk); while (!s_tready);
    predict_word(req, tbl, data);
  endtask

  task automatic load_term(input logic [1:0] tbl, input logic [7:0] idx,
                           input logic [63:0] cond, input logic [63:0] res);
    send_word(REQ_LOAD, tbl, pack_word(idx, cond, res, '0, '0, '0));
  endtask

  task automatic status_word(input logic [2:0] req, input logic [5:0] bitn,
                             input logic [63:0] keep, input logic [63:0] frc);
    send_word(req, TBL_PREPARE, pack_word('0, '0, '0, bitn, keep, frc));
  endtask

  task automatic wait_results();
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // APB write: setup cycle, then access until pready
  task automatic reg_write(input logic [2:0] reg_idx, input logic [63:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 3'b000};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_idx == REG_BASE_MASK) base_sens = value;
    else term_count[reg_idx[1:0]] = value[8:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Registers only move while the block is quiet: every result back, and
  // any scan certainly over.
  task automatic set_config(input logic [8:0] p, input logic [8:0] m, input logic [8:0] s,
                            input logic [8:0] d, input logic [63:0] base);
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait_results();
    repeat (SCAN_SETTLE) @(posedge clk);
    reg_write(REG_PREPARE_COUNT, {55'd0, p});
    reg_write(REG_MAIN_COUNT, {55'd0, m});
    reg_write(REG_STATIC_COUNT, {55'd0, s});
    reg_write(REG_DYNAMIC_COUNT, {55'd0, d});
    reg_write(REG_BASE_MASK, base);
  endtask

  // Load every slot in use that has never held a term
  task automatic fill_tables();
    logic [1:0] tbl;
    for (int t = 0; t < 4; t++) begin
      tbl = 2'(t);
      for (int i = 0; i < terms_in_use(term_count[tbl]); i++) begin
        if (!term_loaded[tbl][i]) load_term(tbl, 8'(i), term_mask(), rand64());
      end
    end
  endtask

  task automatic send_random_word(input int recalc_pct);
    logic [2:0]  req;
    logic [1:0]  tbl;
    logic [7:0]  idx;
    logic [5:0]  bitn;
    logic [63:0] cond, res, keep, frc;
    int          pick;
    int          lim;
    tbl  = 2'($urandom_range(3));
    idx  = 8'($urandom_range(255));
    bitn = 6'($urandom_range(63));
    cond = rand64();
    res  = rand64();
    keep = rand64();
    frc  = rand64();
    if ($urandom_range(99) < recalc_pct) begin
      req = REQ_RECALC;
    end else begin
      pick = $urandom_range(99);
      if (pick < 35) req = REQ_LOAD;
      else if (pick < 60) req = REQ_SET;
      else if (pick < 80) req = REQ_CLEAR;
      else if (pick < 92) req = REQ_MASK;
      else if (pick < 95) req = REQ_RSVD_A;
      else if (pick < 98) req = REQ_RSVD_B;
      else req = REQ_RSVD_C;
    end
    case (req)
      REQ_LOAD: begin
        // mostly slots in use; the rest land anywhere, often out of range
        lim = terms_in_use(term_count[tbl]);
        if (lim > 0 && $urandom_range(3) != 0) idx = 8'($urandom_range(lim - 1));
        cond = term_mask();
      end
      REQ_SET, REQ_CLEAR: begin
        if ($urandom_range(9) < 7) bitn = 6'($urandom_range(15));
      end
      REQ_MASK: begin
        if ($urandom_range(1) == 1) frc = term_mask();
        if ($urandom_range(3) == 0) keep = '1;
      end
      default: ;
    endcase
    send_word(req, tbl, pack_word(idx, cond, res, bitn, keep, frc));
  endtask

  task automatic run_random(input int n, input int recalc_pct, input bit pause_for_results);
    for (int i = 0; i < n; i++) begin
      send_random_word(recalc_pct);
      // hold the sender until the result side has fully drained
      if (pause_for_results && (i % 20) == 19) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait_results();
      end
    end
  endtask

  task automatic random_config();
    set_config(9'($urandom_range(12)), 9'($urandom_range(12)), 9'($urandom_range(12)),
               9'($urandom_range(12)), rand64());
    fill_tables();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and the comparison against the queue.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  task automatic report_error(input string msg);
    $display("tb: mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    recalc_result_t r;
    if (!rst && m_tvalid && m_tready) begin
      if (results_due.size() == 0) begin
        report_error($sformatf("result word with none expected, data %h", m_tdata));
      end else begin
        r = results_due.pop_front();
        if (m_tdata[63:0] !== r.out_word)
          report_error($sformatf("output_word %h, expected %h", m_tdata[63:0], r.out_word));
        if (m_tdata[127:64] !== r.sens_word)
          report_error($sformatf("sensitive_word %h, expected %h", m_tdata[127:64],
                                 r.sens_word));
        if (m_tuser[0] !== r.pend)
          report_error($sformatf("was_pending %b, expected %b", m_tuser[0], r.pend));
      end
    end
  end

  // Watchdog: any cycle in which a word or a register access goes through
  // restarts the count.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked terms covering every request, the chained prepare stage,
  // ignored loads, reserved codes and status writes that change nothing.
  task automatic test_directed_terms();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    // straight out of reset: nothing in use, base mask zero
    status_word(REQ_RECALC, '0, '0, '0);
    set_config(9'd2, 9'd2, 9'd1, 9'd1, 64'h8000_0000_0000_0001);
    load_term(TBL_PREPARE, 8'd0, 64'h1, 64'h20);
    load_term(TBL_PREPARE, 8'd1, '1, '1);
    load_term(TBL_MAIN, 8'd0, 64'h20, 64'hA5A5_5A5A_F00F_0FF0);
    load_term(TBL_MAIN, 8'd1, '0, 64'h1);
    load_term(TBL_STATIC, 8'd0, 64'h8000_0000_0000_0000, 64'h2);
    load_term(TBL_DYNAMIC, 8'd0, '0, 64'h4);
    // beyond the count in use: both dropped
    load_term(TBL_MAIN, 8'd2, '0, '1);
    load_term(TBL_STATIC, 8'd255, '0, '1);
    status_word(REQ_RECALC, '0, '0, '0);
    // bit 0 fires the first prepare term, which in turn fires main term 0
    status_word(REQ_SET, 6'd0, '0, '0);
    status_word(REQ_RECALC, '0, '0, '0);
    // setting it again changes nothing, so no pending flag
    status_word(REQ_SET, 6'd0, '0, '0);
    status_word(REQ_RECALC, '0, '0, '0);
    status_word(REQ_SET, 6'd63, '0, '0);
    status_word(REQ_CLEAR, 6'd63, '0, '0);
    status_word(REQ_CLEAR, 6'd63, '0, '0);
    status_word(REQ_RECALC, '0, '0, '0);
    // every contact closed: all terms fire
    status_word(REQ_MASK, '0, '0, '1);
    status_word(REQ_RECALC, '0, '0, '0);
    status_word(REQ_MASK, '0, '1, '0);
    send_word(REQ_RSVD_A, TBL_DYNAMIC, pack_word('1, '1, '1, '1, '0, '0));
    send_word(REQ_RSVD_B, TBL_MAIN, pack_word('1, '1, '1, '1, '1, '1));
    send_word(REQ_RSVD_C, TBL_STATIC, pack_word('0, '0, '0, '0, '0, '1));
    status_word(REQ_RECALC, '0, '0, '0);
    status_word(REQ_MASK, '0, '0, '0);
    status_word(REQ_RECALC, '0, '0, '0);
  endtask

  task automatic test_random_no_idle();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    random_config();
    run_random(40, 22, 1'b0);
  endtask

  task automatic test_random_sender_idle();
    tx_idle_pct = 67;
    rx_stall_pct = 0;
    random_config();
    run_random(40, 22, 1'b0);
  endtask

  task automatic test_random_receiver_stall();
    tx_idle_pct = 0;
    rx_stall_pct = 67;
    random_config();
    run_random(40, 22, 1'b0);
  endtask

  task automatic test_random_both_idle();
    tx_idle_pct = 21;
    rx_stall_pct = 21;
    random_config();
    run_random(40, 22, 1'b1);
  endtask

  // Widest scan: a prepare count past the table size (acts as full), a short
  // main table, no static terms and every base bit set. Few scans, they are slow.
  task automatic test_full_tables();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    set_config(9'h1FF, 9'd4, 9'd0, 9'd3, '1);
    fill_tables();
    run_random(30, 10, 1'b0);
  endtask

  initial begin
    for (int t = 0; t < 4; t++) begin
      term_count[t] = '0;
      for (int i = 0; i < TERM_LIMIT; i++) begin
        term_cond[t][i] = '0;
        term_out[t][i] = '0;
        term_loaded[t][i] = 1'b0;
      end
    end
    contact_status = '0;
    change_pending = 1'b0;
    base_sens = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_terms();
    test_random_no_idle();
    test_random_sender_idle();
    test_full_tables();
    test_random_receiver_stall();
    test_random_both_idle();
    // back to empty tables so zero counts are seen again under random traffic
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    set_config(9'd0, 9'd0, 9'd0, 9'd0, '0);
    run_random(20, 30, 1'b0);

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait_results();
    // stray results would show up in this window
    repeat (SCAN_SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
